// ===== rtl/core/gcsfe_pkg.sv =====
package gcsfe_pkg;

    localparam int CODE_BYTES_DEFAULT  = 64;
    localparam int QUEUE_DEPTH_DEFAULT = 4;
    localparam int ROM_DEPTH           = 64;
    localparam int ROM_ADDR_W          = 6;
    localparam int FRAME_SYMBOLS       = 30;
    localparam int SYM_W               = 5;

    localparam logic [6:0] PREAMBLE_BITS  = 7'b1110010;
    localparam logic [6:0] POSTAMBLE_BITS = 7'b1011000;

    typedef enum logic
    {
        OP_LOAD = 1'b0,
        OP_TICK = 1'b1
    } op_t;

    // one chip byte to fetch: code select, ROM address, end-of-frame flag
    typedef struct packed
    {
        logic                  sel;
        logic [ROM_ADDR_W-1:0] addr;
        logic                  last;
    } req_t;

    localparam logic [7:0] PARITY_MASKS [0:7] = '{
        8'hA5, 8'h77, 8'h1E, 8'h8F, 8'hE2, 8'hF1, 8'hDD, 8'h39
    };

    localparam logic [7:0] ZERO_CODE_ROM [0:ROM_DEPTH-1] = '{
        8'h01, 8'h5E, 8'hD4, 8'h61, 8'h0B, 8'hF3, 8'h31, 8'h5C,
        8'h66, 8'h92, 8'h5B, 8'h2A, 8'hE0, 8'hA3, 8'h00, 8'hE1,
        8'hBB, 8'h9F, 8'h31, 8'hCF, 8'hF7, 8'hC0, 8'hB2, 8'h75,
        8'hAA, 8'hA7, 8'hA5, 8'h12, 8'h0F, 8'h5B, 8'h02, 8'h3D,
        8'h4E, 8'h60, 8'h8E, 8'h17, 8'h34, 8'h85, 8'h61, 8'h45,
        8'h06, 8'hA2, 8'h36, 8'h2F, 8'hA9, 8'h1F, 8'hD7, 8'hFD,
        8'h9D, 8'h48, 8'h19, 8'h18, 8'hAF, 8'h36, 8'h93, 8'h00,
        8'h10, 8'h85, 8'h28, 8'h1D, 8'h5C, 8'hAF, 8'h64, 8'hDA
    };

    localparam logic [7:0] ONE_CODE_ROM [0:ROM_DEPTH-1] = '{
        8'hFD, 8'h3E, 8'h77, 8'hD5, 8'h25, 8'hEF, 8'h2C, 8'h69,
        8'h2A, 8'hE9, 8'h3C, 8'hC4, 8'h07, 8'h93, 8'hC5, 8'h07,
        8'h37, 8'h1F, 8'h7B, 8'hD1, 8'hBA, 8'h07, 8'h90, 8'h37,
        8'hDF, 8'h5A, 8'hED, 8'hC8, 8'h8C, 8'h69, 8'h97, 8'h29,
        8'hAC, 8'hD9, 8'hD6, 8'h1A, 8'hD6, 8'hA8, 8'h05, 8'hD3,
        8'h6A, 8'hCB, 8'hD6, 8'h52, 8'h3F, 8'hE7, 8'h82, 8'h86,
        8'h6E, 8'h9A, 8'h65, 8'hA6, 8'h2E, 8'h54, 8'hF4, 8'h7A,
        8'hCB, 8'h2E, 8'h63, 8'hBF, 8'h54, 8'hC4, 8'hD4, 8'h54
    };

    function automatic logic [7:0] parity_of(input logic [7:0] data);
        logic [7:0] p;
        p = '0;
        for (int i = 0; i < 8; i++)
        begin
            p[7-i] = ^(data & PARITY_MASKS[i]);
        end
        return p;
    endfunction

endpackage

// ===== rtl/core/gold_code_spread_frame_encoder_core.sv =====
// Gold code spreader with (16,8) block-coded frames.
// Input stream s_*: tuser is the op (0 = load data byte, 1 = tick), tdata
// the data byte. A load while idle builds a 30-symbol frame (preamble,
// parity, data, postamble); a load during a frame is dropped. Each tick
// during a frame yields one chip byte on m_* from the code chosen by the
// current symbol, CODE_BYTES bytes per symbol; tlast marks the final byte
// of the frame, after which the block is idle again. Ticks while idle and
// all loads give no output.
// Throughput: one input item per cycle while the request queue is not
// full. An accepted tick is written into the request queue and then, once
// the output slot is free or draining, looked up in the ROM into the output
// register that drives m_tdata.
// The front keeps the frame counters; the back does the ROM lookup.
// When the receiver stalls, the output register holds and the request queue
// (QUEUE_DEPTH entries) absorbs ticks; s_tready drops once it is full.
// Reset (rst_n low) empties queue and output and leaves the block idle.
module gold_code_spread_frame_encoder_core #(
    parameter int CODE_BYTES  = gcsfe_pkg::CODE_BYTES_DEFAULT,
    parameter int QUEUE_DEPTH = gcsfe_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic       clk,
    input  logic       rst_n,
    input  logic       s_tvalid,
    output logic       s_tready,
    input  logic [7:0] s_tdata,   // data_byte[7:0]
    input  logic       s_tuser,   // op
    output logic       m_tvalid,
    input  logic       m_tready,
    output logic [7:0] m_tdata,   // chip_byte[7:0]
    output logic       m_tlast    // frame_last
);

    logic            push;
    logic            pop;
    logic            q_valid;
    logic            q_full;
    gcsfe_pkg::req_t push_req;
    gcsfe_pkg::req_t q_req;

    gcsfe_front #(
        .CODE_BYTES (CODE_BYTES)
    ) u_front (
        .clk      (clk),
        .rst_n    (rst_n),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_full   (q_full),
        .push     (push),
        .push_req (push_req)
    );

    gcsfe_req_fifo #(
        .DEPTH (QUEUE_DEPTH)
    ) u_queue (
        .clk      (clk),
        .rst_n    (rst_n),
        .push     (push),
        .push_req (push_req),
        .pop      (pop),
        .q_valid  (q_valid),
        .q_full   (q_full),
        .q_req    (q_req)
    );

    gcsfe_back u_back (
        .clk      (clk),
        .rst_n    (rst_n),
        .q_valid  (q_valid),
        .q_req    (q_req),
        .pop      (pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

// ===== rtl/core/gcsfe_front.sv =====
module gcsfe_front #(
    parameter int CODE_BYTES = gcsfe_pkg::CODE_BYTES_DEFAULT
) (
    input  logic              clk,
    input  logic              rst_n,
    input  logic              s_tvalid,
    output logic              s_tready,
    input  logic [7:0]        s_tdata,   // data_byte[7:0]
    input  logic              s_tuser,   // op
    input  logic              q_full,
    output logic              push,
    output gcsfe_pkg::req_t   push_req
);

    localparam int POS_W = (CODE_BYTES > 1) ? $clog2(CODE_BYTES) : 1;
    localparam int SYM_W = gcsfe_pkg::SYM_W;

    logic                              active_reg, active_next;
    logic [gcsfe_pkg::FRAME_SYMBOLS-1:0] pattern_reg, pattern_next;
    logic [SYM_W-1:0]                  sym_reg, sym_next;
    logic [POS_W-1:0]                  pos_reg, pos_next;
    logic [7:0]                        pos_ext;
    logic                              accept;
    logic                              last_byte;
    logic                              last_sym;

    assign s_tready  = !q_full;
    assign accept    = s_tvalid && s_tready;
    assign pos_ext   = 8'(pos_reg);
    assign last_byte = (pos_reg == POS_W'(CODE_BYTES - 1));
    assign last_sym  = (sym_reg == SYM_W'(gcsfe_pkg::FRAME_SYMBOLS - 1));

    // current symbol always sits in the top bit; address wraps on the ROM size
    assign push_req.sel  = pattern_reg[gcsfe_pkg::FRAME_SYMBOLS-1];
    assign push_req.addr = pos_ext[gcsfe_pkg::ROM_ADDR_W-1:0];
    assign push_req.last = last_sym && last_byte;

    always_comb
    begin
        active_next  = active_reg;
        pattern_next = pattern_reg;
        sym_next     = sym_reg;
        pos_next     = pos_reg;
        push         = 1'b0;
        if (accept)
        begin
            if (s_tuser == gcsfe_pkg::OP_LOAD)
            begin
                // drop a load that arrives mid-frame
                if (!active_reg)
                begin
                    pattern_next = {gcsfe_pkg::PREAMBLE_BITS,
                                    gcsfe_pkg::parity_of(s_tdata),
                                    s_tdata,
                                    gcsfe_pkg::POSTAMBLE_BITS};
                    sym_next     = '0;
                    pos_next     = '0;
                    active_next  = 1'b1;
                end
            end
            else if (active_reg)
            begin
                push = 1'b1;
                if (last_byte)
                begin
                    pos_next = '0;
                    if (last_sym)
                    begin
                        sym_next    = '0;
                        active_next = 1'b0;
                    end
                    else
                    begin
                        sym_next     = sym_reg + SYM_W'(1);
                        pattern_next = {pattern_reg[gcsfe_pkg::FRAME_SYMBOLS-2:0], 1'b0};
                    end
                end
                else
                begin
                    pos_next = pos_reg + POS_W'(1);
                end
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            active_reg  <= 1'b0;
            pattern_reg <= '0;
            sym_reg     <= '0;
            pos_reg     <= '0;
        end
        else
        begin
            active_reg  <= active_next;
            pattern_reg <= pattern_next;
            sym_reg     <= sym_next;
            pos_reg     <= pos_next;
        end
    end

`ifndef SYNTH
    a_last_ends_frame: assert property (@(posedge clk) disable iff (!rst_n)
        push && push_req.last |=> !active_reg)
        else $error("frame still active after last chip request");

    a_idle_counters_clear: assert property (@(posedge clk) disable iff (!rst_n)
        !active_reg |-> (sym_reg == '0) && (pos_reg == '0))
        else $error("position counters not cleared while idle");
`endif

endmodule

// ===== rtl/core/gcsfe_req_fifo.sv =====
module gcsfe_req_fifo #(
    parameter int DEPTH = gcsfe_pkg::QUEUE_DEPTH_DEFAULT
) (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            push,
    input  gcsfe_pkg::req_t push_req,
    input  logic            pop,
    output logic            q_valid,
    output logic            q_full,
    output gcsfe_pkg::req_t q_req
);

    localparam int PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
    localparam int CNT_W = $clog2(DEPTH + 1);

    gcsfe_pkg::req_t   mem_reg [0:DEPTH-1];
    logic [PTR_W-1:0]  wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0]  rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0]  count_reg, count_next;

    assign q_valid = (count_reg != '0);
    assign q_full  = (count_reg == CNT_W'(DEPTH));
    assign q_req   = mem_reg[rd_ptr_reg];

    always_comb
    begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        count_next  = count_reg;
        if (push)
        begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop)
        begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop)
        begin
            count_next = count_reg + CNT_W'(1);
        end
        else if (pop && !push)
        begin
            count_next = count_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge clk)
    begin
        if (push)
        begin
            mem_reg[wr_ptr_reg] <= push_req;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            count_reg  <= '0;
        end
        else
        begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            count_reg  <= count_next;
        end
    end

`ifndef SYNTH
    a_no_overflow: assert property (@(posedge clk) disable iff (!rst_n)
        !(push && q_full))
        else $error("request pushed into full queue");

    a_no_underflow: assert property (@(posedge clk) disable iff (!rst_n)
        pop |-> q_valid)
        else $error("request popped from empty queue");
`endif

endmodule

// ===== rtl/core/gcsfe_back.sv =====
module gcsfe_back (
    input  logic            clk,
    input  logic            rst_n,
    input  logic            q_valid,
    input  gcsfe_pkg::req_t q_req,
    output logic            pop,
    output logic            m_tvalid,
    input  logic            m_tready,
    output logic [7:0]      m_tdata,   // chip_byte[7:0]
    output logic            m_tlast    // frame_last
);

    logic       valid_reg, valid_next;
    logic [7:0] chip_reg, chip_next;
    logic       last_reg, last_next;

    // take a request whenever the output slot is free or draining
    assign pop = q_valid && (!valid_reg || m_tready);

    always_comb
    begin
        valid_next = valid_reg;
        chip_next  = chip_reg;
        last_next  = last_reg;
        if (pop)
        begin
            valid_next = 1'b1;
            chip_next  = q_req.sel ? gcsfe_pkg::ONE_CODE_ROM[q_req.addr]
                                   : gcsfe_pkg::ZERO_CODE_ROM[q_req.addr];
            last_next  = q_req.last;
        end
        else if (m_tready)
        begin
            valid_next = 1'b0;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            valid_reg <= 1'b0;
        end
        else
        begin
            valid_reg <= valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        chip_reg <= chip_next;
        last_reg <= last_next;
    end

    assign m_tvalid = valid_reg;
    assign m_tdata  = chip_reg;
    assign m_tlast  = last_reg;

`ifndef SYNTH
    a_pop_fills_output: assert property (@(posedge clk) disable iff (!rst_n)
        pop |=> m_tvalid)
        else $error("popped request did not reach the output");
`endif

endmodule

// ===== verif/gold_code_spread_frame_encoder_core_test.sv =====
`timescale 1ns / 1ps

module gold_code_spread_frame_encoder_core_test;

    localparam int SPREAD_BYTES   = gcsfe_pkg::CODE_BYTES_DEFAULT;
    localparam int RANDOM_ITEMS   = 160;
    localparam int QUIET_ITEMS    = 40;
    localparam int HOLD_CYCLES    = 48;
    localparam int DRAIN_CYCLES   = 8;
    localparam int WATCHDOG_LIMIT = 1000;

    typedef struct packed
    {
        logic [7:0] code_byte;
        logic       frame_end;
    } chip_byte_t;

    logic       clk      = 1'b0;
    logic       rst_n    = 1'b0;
    logic       s_tvalid = 1'b0;
    logic       s_tready;
    logic [7:0] s_tdata  = 8'h00;   // data_byte[7:0]
    logic       s_tuser  = 1'b0;    // op
    logic       m_tvalid;
    logic       m_tready = 1'b0;
    logic [7:0] m_tdata;            // chip_byte[7:0]
    logic       m_tlast;            // frame_last

    // spreader state as the block should hold it
    logic [gcsfe_pkg::FRAME_SYMBOLS-1:0] frame_symbols = '0;
    int                       symbol_index  = 0;
    int                       byte_index    = 0;
    bit                       frame_sending = 1'b0;

    chip_byte_t pending_chips[$];
    int         errors = 0;

    // stimulus pacing
    bit quiet_tail      = 1'b0;
    bit hold_request    = 1'b0;
    int hold_left       = 0;
    int rx_calm_left    = 0;
    int rx_stall_left   = 0;
    int tx_calm_left    = 0;

    gold_code_spread_frame_encoder_core #(
        .CODE_BYTES(SPREAD_BYTES)
    ) dut (
        .clk     (clk),
        .rst_n   (rst_n),
        .s_tvalid(s_tvalid),
        .s_tready(s_tready),
        .s_tdata (s_tdata),
        .s_tuser (s_tuser),
        .m_tvalid(m_tvalid),
        .m_tready(m_tready),
        .m_tdata (m_tdata),
        .m_tlast (m_tlast)
    );

    always
    begin
        #1 clk = 1'b1;
        #1 clk = 1'b0;
    end

    function automatic logic [7:0] block_parity(input logic [7:0] d);
        return {d[7] ^ d[5] ^ d[2] ^ d[0],
                d[6] ^ d[5] ^ d[4] ^ d[2] ^ d[1] ^ d[0],
                d[4] ^ d[3] ^ d[2] ^ d[1],
                d[7] ^ d[3] ^ d[2] ^ d[1] ^ d[0],
                d[7] ^ d[6] ^ d[5] ^ d[1],
                d[7] ^ d[6] ^ d[5] ^ d[4] ^ d[0],
                d[7] ^ d[6] ^ d[4] ^ d[3] ^ d[2] ^ d[0],
                d[5] ^ d[4] ^ d[3] ^ d[0]};
    endfunction

    // advance the spreader by one request; returns 1 when a chip byte is due
    function automatic bit spread_step(input gcsfe_pkg::op_t op, input logic [7:0] data,
                                       output chip_byte_t chip);
        logic sym;
        bit   end_of_symbol;
        chip = '0;
        if (op == gcsfe_pkg::OP_LOAD)
        begin
            if (!frame_sending)
            begin
                frame_symbols = {gcsfe_pkg::PREAMBLE_BITS, block_parity(data), data,
                                 gcsfe_pkg::POSTAMBLE_BITS};
                symbol_index  = 0;
                byte_index    = 0;
                frame_sending = 1'b1;
            end
            return 1'b0;
        end
        if (!frame_sending)
            return 1'b0;
        sym = frame_symbols[gcsfe_pkg::FRAME_SYMBOLS - 1 - symbol_index];
        chip.code_byte = sym ? gcsfe_pkg::ONE_CODE_ROM[byte_index % gcsfe_pkg::ROM_DEPTH]
                             : gcsfe_pkg::ZERO_CODE_ROM[byte_index % gcsfe_pkg::ROM_DEPTH];
        end_of_symbol  = (byte_index + 1 >= SPREAD_BYTES);
        chip.frame_end = end_of_symbol && (symbol_index == gcsfe_pkg::FRAME_SYMBOLS - 1);
        if (end_of_symbol)
        begin
            byte_index = 0;
            if (chip.frame_end)
            begin
                symbol_index  = 0;
                frame_sending = 1'b0;
            end
            else
                symbol_index++;
        end
        else
            byte_index++;
        return 1'b1;
    endfunction

    task automatic report_mismatch(input string what, input logic [7:0] got,
                                   input logic [7:0] want);
        $display("ERROR at %0t: %s: got %02h, expected %02h", $realtime, what, got, want);
        errors++;
    endtask

    task automatic send_request(input gcsfe_pkg::op_t op, input logic [7:0] data);
        chip_byte_t chip;
        @(negedge clk);
        s_tvalid <= 1'b1;
        s_tuser  <= op;
        s_tdata  <= data;
        do
            @(posedge clk);
        while (!s_tready);
        if (spread_step(op, data, chip))
            pending_chips.push_back(chip);
    endtask

    // drop valid for a burst now and then, with gap-free stretches between
    task automatic pace_sender();
        int gap;
        if (quiet_tail)
            return;
        if (tx_calm_left > 0)
        begin
            tx_calm_left--;
            return;
        end
        if ($urandom_range(0, 63) == 0)
            tx_calm_left = $urandom_range(30, 150);
        else if ($urandom_range(0, 3) == 0)
        begin
            gap = $urandom_range(1, 4);
            @(negedge clk);
            s_tvalid <= 1'b0;
            repeat (gap - 1) @(negedge clk);
        end
    endtask

    task automatic wait_drained();
        @(negedge clk);
        s_tvalid <= 1'b0;
        while (pending_chips.size() != 0)
            @(posedge clk);
    endtask

    task automatic test_idle_ticks();
        send_request(gcsfe_pkg::OP_TICK, 8'h00);
        pace_sender();
        send_request(gcsfe_pkg::OP_TICK, 8'hFF);
        pace_sender();
    endtask

    task automatic test_load_during_frame();
        send_request(gcsfe_pkg::OP_LOAD, 8'hFF);
        repeat (6)
        begin
            send_request(gcsfe_pkg::OP_TICK, 8'($urandom_range(0, 255)));
            pace_sender();
        end
        // both loads land mid-frame and must be dropped
        send_request(gcsfe_pkg::OP_LOAD, 8'h00);
        send_request(gcsfe_pkg::OP_LOAD, 8'h5A);
        repeat (6)
        begin
            send_request(gcsfe_pkg::OP_TICK, 8'($urandom_range(0, 255)));
            pace_sender();
        end
        wait_drained();
    endtask

    task automatic test_output_backpressure();
        hold_request = 1'b1;
        // keep offering ticks so the request queue fills and the input stalls
        repeat (16)
            send_request(gcsfe_pkg::OP_TICK, 8'($urandom_range(0, 255)));
        wait_drained();
    endtask

    task automatic test_frame_end();
        while (frame_sending)
        begin
            send_request(gcsfe_pkg::OP_TICK, 8'($urandom_range(0, 255)));
            pace_sender();
        end
        // load straight after the last tick of a frame
        send_request(gcsfe_pkg::OP_LOAD, 8'h96);
        wait_drained();
    endtask

    task automatic test_random_traffic();
        int              useful;
        gcsfe_pkg::op_t  op;
        logic [7:0]      data;
        useful = 0;
        while (useful < RANDOM_ITEMS)
        begin
            quiet_tail = (useful >= RANDOM_ITEMS - QUIET_ITEMS);
            data = 8'($urandom_range(0, 255));
            if (frame_sending)
                op = ($urandom_range(0, 63) == 0) ? gcsfe_pkg::OP_LOAD : gcsfe_pkg::OP_TICK;
            else
                op = ($urandom_range(0, 3) == 0) ? gcsfe_pkg::OP_TICK : gcsfe_pkg::OP_LOAD;
            if ((op == gcsfe_pkg::OP_TICK) == frame_sending)
                useful++;
            send_request(op, data);
            pace_sender();
        end
        wait_drained();
    endtask

    always @(negedge clk)
    begin : drive_ready
        if (hold_request)
        begin
            hold_left    = HOLD_CYCLES;
            hold_request = 1'b0;
        end
        if (hold_left > 0)
        begin
            hold_left--;
            m_tready <= 1'b0;
        end
        else if (quiet_tail || rx_calm_left > 0)
        begin
            if (rx_calm_left > 0)
                rx_calm_left--;
            m_tready <= 1'b1;
        end
        else if (rx_stall_left > 0)
        begin
            rx_stall_left--;
            m_tready <= 1'b0;
        end
        else
        begin
            case ($urandom_range(0, 15))
                0:
                begin
                    rx_calm_left = $urandom_range(32, 160);
                    m_tready <= 1'b1;
                end
                1, 2, 3:
                begin
                    rx_stall_left = $urandom_range(0, 3);
                    m_tready <= 1'b0;
                end
                default:
                    m_tready <= 1'b1;
            endcase
        end
    end

    always @(posedge clk)
    begin : check_chips
        chip_byte_t want;
        if (rst_n && m_tvalid && m_tready)
        begin
            if (pending_chips.size() == 0)
                report_mismatch("chip byte with none pending", m_tdata, 8'h00);
            else
            begin
                want = pending_chips.pop_front();
                if (m_tdata !== want.code_byte)
                    report_mismatch("chip byte", m_tdata, want.code_byte);
                if (m_tlast !== want.frame_end)
                    report_mismatch("frame last flag", {7'b0, m_tlast}, {7'b0, want.frame_end});
            end
        end
    end

    initial
    begin : watchdog
        int quiet_cycles;
        quiet_cycles = 0;
        while (quiet_cycles < WATCHDOG_LIMIT)
        begin
            @(posedge clk);
            if ((s_tvalid && s_tready) || (m_tvalid && m_tready))
                quiet_cycles = 0;
            else
                quiet_cycles++;
        end
        $display("ERROR: no progress for %0d cycles", WATCHDOG_LIMIT);
        $display("gold_code_spread_frame_encoder_core: mismatch");
        $finish;
    end

    initial
    begin
        repeat (3) @(posedge clk);
        @(negedge clk);
        rst_n <= 1'b1;
        test_idle_ticks();
        test_load_during_frame();
        test_output_backpressure();
        test_frame_end();
        test_random_traffic();
        repeat (DRAIN_CYCLES) @(posedge clk);
        if (errors == 0)
            $display("gold_code_spread_frame_encoder_core: match");
        else
            $display("gold_code_spread_frame_encoder_core: mismatch");
        $finish;
    end

endmodule
